// ----- design/ppbf_pkg.sv -----
// Shared constants and types for the point projection box filter.
`timescale 1ns / 1ps

package ppbf_pkg;

  localparam int NUM_COEFF   = 6;
  localparam int QBITS       = 17;          // quotient bits before saturation
  localparam int DIV_STAGES  = QBITS + 1;   // one stage per bit plus rounding
  localparam int MAC_STAGES  = 3;
  localparam int NUM_STAGES  = MAC_STAGES + DIV_STAGES + 1;
  localparam int CFG_IDX_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX = 4'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [23:0]        color;
    logic [21:0]        index;
  } side_t;

endpackage

// ----- design/ppbf_mac.sv -----
// Matrix times homogeneous point: products, row sums, then magnitudes and signs.
`timescale 1ns / 1ps

module ppbf_mac (
  input  logic                                    clk,
  input  logic [ppbf_pkg::MAC_STAGES-1:0]         en,
  input  logic [ppbf_pkg::NUM_COEFF-1:0][63:0]    coeff,
  input  logic signed [31:0]                      x,
  input  logic signed [31:0]                      y,
  input  logic signed [31:0]                      z,
  output logic [63:0]                             mag_a,
  output logic [63:0]                             mag_b,
  output logic [63:0]                             mag_w,
  output logic                                    neg_a,
  output logic                                    neg_b,
  output logic                                    w_zero
);

  logic signed [63:0] term [3][4];
  logic signed [63:0] sum [3];

  genvar r;
  generate
    for (r = 0; r < 3; r++) begin : g_row
      logic signed [31:0] c0, c1, c2, c3;
      logic signed [63:0] m0, m1, m2;
      assign c0 = coeff[2*r][31:0];
      assign c1 = coeff[2*r][63:32];
      assign c2 = coeff[2*r+1][31:0];
      assign c3 = coeff[2*r+1][63:32];
      assign m0 = c0 * x;
      assign m1 = c1 * y;
      assign m2 = c2 * z;

      // Arithmetic shift gives the floor of the division by four.
      always_ff @(posedge clk) begin
        if (en[0]) begin
          term[r][0] <= m0 >>> 2;
          term[r][1] <= m1 >>> 2;
          term[r][2] <= m2 >>> 2;
          term[r][3] <= {{18{c3[31]}}, c3, 14'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en[1]) begin
          sum[r] <= term[r][0] + term[r][1] + term[r][2] + term[r][3];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag_a  <= sum[0][63] ? 64'(-sum[0]) : 64'(sum[0]);
      mag_b  <= sum[1][63] ? 64'(-sum[1]) : 64'(sum[1]);
      mag_w  <= sum[2][63] ? 64'(-sum[2]) : 64'(sum[2]);
      neg_a  <= sum[0][63] ^ sum[2][63];
      neg_b  <= sum[1][63] ^ sum[2][63];
      w_zero <= (sum[2] == 64'sd0);
    end
  end

endmodule

// ----- design/ppbf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`timescale 1ns / 1ps

module ppbf_div (
  input  logic                                clk,
  input  logic [ppbf_pkg::DIV_STAGES-1:0]     en,
  input  logic [63:0]                         num,
  input  logic [63:0]                         den,
  input  logic                                neg,
  output logic signed [15:0]                  quot
);

  localparam int QB = ppbf_pkg::QBITS;

  logic [63:0]   rem [QB];
  logic [63:0]   dd  [QB];
  logic [QB-1:0] qq  [QB];
  logic          ng  [QB];
  logic          big [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_bit
      localparam int B = QB - 1 - k;
      logic [63:0]    rem_in, dd_in;
      logic [QB-1:0]  q_in;
      logic           ng_in, big_in, ge;
      logic [79:0]    shifted;

      if (k == 0) begin : g_first
        assign rem_in = num;
        assign dd_in  = den;
        assign q_in   = '0;
        assign ng_in  = neg;
        // Quotient of 2^17 or more saturates whatever the rounding.
        assign big_in = ({17'b0, num} >= {den, 17'b0});
      end else begin : g_next
        assign rem_in = rem[k-1];
        assign dd_in  = dd[k-1];
        assign q_in   = qq[k-1];
        assign ng_in  = ng[k-1];
        assign big_in = big[k-1];
      end

      assign shifted = {16'b0, dd_in} << B;
      assign ge      = ({16'b0, rem_in} >= shifted);

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= ge ? (rem_in - shifted[63:0]) : rem_in;
          qq[k]  <= q_in | (ge ? (QB'(1) << B) : '0);
          dd[k]  <= dd_in;
          ng[k]  <= ng_in;
          big[k] <= big_in;
        end
      end
    end
  endgenerate

  logic [64:0]   rem2;
  logic          inc;
  logic [QB:0]   qr;

  // Ties go to the even quotient.
  assign rem2 = {rem[QB-1], 1'b0};
  assign inc  = (rem2 > {1'b0, dd[QB-1]}) ||
                ((rem2 == {1'b0, dd[QB-1]}) && qq[QB-1][0]);
  assign qr   = {1'b0, qq[QB-1]} + (QB+1)'(inc);

  always_ff @(posedge clk) begin
    if (en[QB]) begin
      if (ng[QB-1]) begin
        quot <= (big[QB-1] || qr >= (QB+1)'(32768)) ? -16'sd32768 : 16'(-qr);
      end else begin
        quot <= (big[QB-1] || qr >= (QB+1)'(32767)) ? 16'sd32767 : 16'(qr);
      end
    end
  end

endmodule

// ----- design/point_projection_box_filter.sv -----
// Top level: configuration registers, pipeline control, box test and output register.
//
//  channel | signals                                  | accepted when
//  --------+------------------------------------------+---------------------------
//  input   | in_valid, in_ready, point_*              | in_valid && in_ready
//  output  | out_valid, out_ready, out_*, pixel_u/v   | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data              | cfg_we
//
// One item per cycle unless the output stalls; stages: multiply, row sum, magnitude,
// 17 divider bit stages, rounding, and the box test into the output register.
// Each stage loads when it is empty or its item moves on, so a stall at the output
// fills empty stages before blocking the input. Reset clears the valid bits and the
// configuration registers; dropped items free their slot at the stage where they are
// rejected.
`timescale 1ns / 1ps

module point_projection_box_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ppbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 point_x,
  input  logic signed [31:0]                 point_y,
  input  logic signed [31:0]                 point_z,
  input  logic [23:0]                        point_color,
  input  logic [21:0]                        point_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_x,
  output logic signed [31:0]                 out_y,
  output logic signed [31:0]                 out_z,
  output logic [23:0]                        out_color,
  output logic [21:0]                        out_index,
  output logic signed [15:0]                 pixel_u,
  output logic signed [15:0]                 pixel_v
);

  localparam int NS  = ppbf_pkg::NUM_STAGES;
  localparam int MS  = ppbf_pkg::MAC_STAGES;
  localparam int DS  = ppbf_pkg::DIV_STAGES;

  logic [ppbf_pkg::NUM_COEFF-1:0][63:0] coeff;
  logic [31:0] box_min, box_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff   <= '0;
      box_min <= '0;
      box_max <= '0;
    end else if (cfg_we) begin
      if (cfg_index < ppbf_pkg::CFG_IDX_W'(ppbf_pkg::NUM_COEFF)) begin
        coeff[cfg_index[2:0]] <= cfg_data;
      end else if (cfg_index == ppbf_pkg::REG_BOX_MIN) begin
        box_min <= cfg_data[31:0];
      end else if (cfg_index == ppbf_pkg::REG_BOX_MAX) begin
        box_max <= cfg_data[31:0];
      end
    end
  end

  logic [NS-1:0]     vld;
  logic [NS-1:0]     free;
  ppbf_pkg::side_t   side [NS];

  always_comb begin
    free[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
  end

  assign in_ready = free[0];

  logic [63:0] mag_a, mag_b, mag_w;
  logic        neg_a, neg_b, w_zero;
  logic signed [15:0] u, v;

  ppbf_mac u_mac (
    .clk    (clk),
    .en     (free[MS-1:0]),
    .coeff  (coeff),
    .x      (point_x),
    .y      (point_y),
    .z      (point_z),
    .mag_a  (mag_a),
    .mag_b  (mag_b),
    .mag_w  (mag_w),
    .neg_a  (neg_a),
    .neg_b  (neg_b),
    .w_zero (w_zero)
  );

  ppbf_div u_div_u (
    .clk  (clk),
    .en   (free[MS+DS-1:MS]),
    .num  (mag_a),
    .den  (mag_w),
    .neg  (neg_a),
    .quot (u)
  );

  ppbf_div u_div_v (
    .clk  (clk),
    .en   (free[MS+DS-1:MS]),
    .num  (mag_b),
    .den  (mag_w),
    .neg  (neg_b),
    .quot (v)
  );

  logic in_box;
  assign in_box = ($signed(box_min[15:0])  <= u) && (u < $signed(box_max[15:0])) &&
                  ($signed(box_min[31:16]) <= v) && (v < $signed(box_max[31:16]));

  // Valid bits: points behind the camera, zero w and points outside the box drop out.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (free[k]) begin
          if (k == 0) begin
            vld[k] <= in_valid && !point_z[31];
          end else if (k == MS) begin
            vld[k] <= vld[k-1] && !w_zero;
          end else if (k == NS - 1) begin
            vld[k] <= vld[k-1] && in_box;
          end else begin
            vld[k] <= vld[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (free[k]) begin
        if (k == 0) begin
          side[k] <= '{x: point_x, y: point_y, z: point_z,
                       color: point_color, index: point_index};
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[NS-1]) begin
      pixel_u <= u;
      pixel_v <= v;
    end
  end

  assign out_valid = vld[NS-1];
  assign out_x     = side[NS-1].x;
  assign out_y     = side[NS-1].y;
  assign out_z     = side[NS-1].z;
  assign out_color = side[NS-1].color;
  assign out_index = side[NS-1].index;

endmodule
